// ===== hw/rtl/compare_match_timer_registers_defines.svh =====
// ---------------------------------------------------------------------------
// Compare-match timer assertion macros
// Concurrent assertion helpers, empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef COMPARE_MATCH_TIMER_REGISTERS_DEFINES_SVH
`define COMPARE_MATCH_TIMER_REGISTERS_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication: when ante holds, cons holds at that edge.
`define CMTR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication: when ante holds, cons holds at the next edge.
`define CMTR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CMTR_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define CMTR_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/cmtr_pkg.sv =====
// ---------------------------------------------------------------------------
// Compare-match timer package
// Action codes, register offsets and the word types shared by the timer.
// ---------------------------------------------------------------------------
package cmtr_pkg;

   typedef enum logic [1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_TICK  = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   localparam logic [11:0] OFF_CONTROL  = 12'h000;
   localparam logic [11:0] OFF_COUNT_LO = 12'h004;
   localparam logic [11:0] OFF_COUNT_HI = 12'h008;
   localparam logic [11:0] OFF_MATCH_LO = 12'h00C;
   localparam logic [11:0] OFF_MATCH_HI = 12'h010;
   localparam logic [11:0] OFF_STATUS   = 12'h014;
   localparam logic [11:0] OFF_IRQ_CLR  = 12'h018;

   // Bit 0 of the control word enables counting.
   localparam int unsigned CTRL_ENABLE_BIT = 0;

   typedef struct packed {
      action_type  action;
      logic [11:0] offset;
      logic [31:0] write_data;
   } item_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        access_status;
      logic        pending_out;
      logic        irq_line;
   } result_type;

endpackage

// ===== hw/rtl/cmtr_regs.sv =====
// ---------------------------------------------------------------------------
// Compare-match timer register file
// Holds the timer state, decodes one word per cycle when fire is set and forms its result.
// ---------------------------------------------------------------------------
module cmtr_regs
   import cmtr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   output result_type result
);

   logic [31:0] control_ff, control_in;
   logic [63:0] count_ff,   count_in;
   logic [63:0] match_ff,   match_in;
   logic        pending_ff, pending_in;
   logic        line_ff,    line_in;
   logic [63:0] count_inc;
   logic        wr_access;
   logic [31:0] read_data;
   logic        access_status;

   assign count_inc = count_ff + 64'd1;
   assign wr_access = (item.action == ACT_WRITE);

   always_comb begin
      control_in    = control_ff;
      count_in      = count_ff;
      match_in      = match_ff;
      pending_in    = pending_ff;
      line_in       = line_ff;
      read_data     = '0;
      access_status = 1'b0;
      case (item.action)
         ACT_READ, ACT_WRITE: begin
            case (item.offset)
               OFF_CONTROL: begin
                  if (wr_access) control_in = item.write_data;
                  else           read_data  = control_ff;
               end
               OFF_COUNT_LO: begin
                  if (wr_access) count_in  = {count_ff[63:32], item.write_data};
                  else           read_data = count_ff[31:0];
               end
               OFF_COUNT_HI: begin
                  if (wr_access) count_in  = {item.write_data, count_ff[31:0]};
                  else           read_data = count_ff[63:32];
               end
               OFF_MATCH_LO: begin
                  if (wr_access) match_in  = {match_ff[63:32], item.write_data};
                  else           read_data = match_ff[31:0];
               end
               OFF_MATCH_HI: begin
                  if (wr_access) match_in  = {item.write_data, match_ff[31:0]};
                  else           read_data = match_ff[63:32];
               end
               OFF_STATUS: begin
                  if (!wr_access) read_data = {31'd0, pending_ff};
               end
               OFF_IRQ_CLR: begin
                  // drop the flag only; the line keeps its level
                  if (wr_access && item.write_data[0]) pending_in = 1'b0;
               end
               default: begin
                  access_status = 1'b1;
               end
            endcase
         end
         ACT_TICK: begin
            if (control_ff[CTRL_ENABLE_BIT]) begin
               count_in = count_inc;
               if (count_inc >= match_ff) begin
                  pending_in = 1'b1;
                  line_in    = 1'b1;
               end
            end
         end
         ACT_CLEAR: begin
            pending_in = 1'b0;
            line_in    = 1'b0;
         end
         default: begin
            pending_in = pending_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff <= '0;
         count_ff   <= '0;
         match_ff   <= '0;
         pending_ff <= 1'b0;
         line_ff    <= 1'b0;
      end else if (fire) begin
         control_ff <= control_in;
         count_ff   <= count_in;
         match_ff   <= match_in;
         pending_ff <= pending_in;
         line_ff    <= line_in;
      end
   end

   assign result.read_data     = read_data;
   assign result.access_status = access_status;
   assign result.pending_out   = pending_in;
   assign result.irq_line      = line_in;

endmodule

// ===== hw/rtl/compare_match_timer_registers.sv =====
// ---------------------------------------------------------------------------
// Compare-match timer with bus register window
// A 64-bit counter, 64-bit compare value, control word, pending flag and
// interrupt line, reached through read, write, tick and clear-event words.
// ---------------------------------------------------------------------------
// Each request word is one of a bus read, a bus write, a timer tick or an
// interrupt clear event, and yields exactly one response word carrying the
// read data, an ignored-offset status bit, and the pending flag and interrupt
// line level after the word. Register map (byte offsets): 0x00 control,
// 0x04/0x08 counter low/high, 0x0C/0x10 compare low/high, 0x14 status (bit 0
// pending, read only), 0x18 interrupt clear (write 1 to bit 0, write only).
// Any other offset, unaligned ones included, is ignored and reported with
// access_status set. A tick with control bit 0 set advances the counter
// (wrapping at 2^64) and, when the new count is at or above the compare
// value, sets both the pending flag and the line; the clear event drops both,
// the clear register drops only the flag.
// Timing: one word per cycle sustained while responses are taken; a request
// passes from the request register into the response register, where the
// response is offered. The request register feeds the decode, the 64-bit
// increment and the compare combinationally; the result lands in the
// response register. A new request is taken while a response waits,
// provided the request register can move on or is empty.
module compare_match_timer_registers
   import cmtr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [11:0] req_offset,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic        rsp_access_status,
   output logic        rsp_pending_out,
   output logic        rsp_irq_line
);

`include "compare_match_timer_registers_defines.svh"

   // request register stage
   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;

   // response register stage
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_result_ff;

   result_type result;
   logic       out_free;
   logic       fire;
   logic       req_accept;

   // The response slot is free when empty or being drained this cycle.
   assign out_free   = !rsp_valid_ff || rsp_ready;
   // Advance the held request into the response register.
   assign fire       = in_valid_ff && out_free;
   assign req_ready  = !in_valid_ff || out_free;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept)  in_valid_in = 1'b1;
      else if (fire)   in_valid_in = 1'b0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire)           rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture payloads; no reset needed.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.action     <= action_type'(req_action);
         in_item_ff.offset     <= req_offset;
         in_item_ff.write_data <= req_write_data;
      end
      if (fire) begin
         rsp_result_ff <= result;
      end
   end

   // Timer state, decode and result forming.
   cmtr_regs u_regs (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_item_ff),
      .result (result)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_result_ff.read_data;
   assign rsp_access_status = rsp_result_ff.access_status;
   assign rsp_pending_out   = rsp_result_ff.pending_out;
   assign rsp_irq_line      = rsp_result_ff.irq_line;

   // The flag is only ever set together with the line, and the line only
   // falls together with the flag.
   `CMTR_ASSERT_IMP(a_pending_implies_line, clock, reset, rsp_valid && rsp_pending_out,
                    rsp_irq_line, "pending flag set while interrupt line low")
   // An ignored access returns no data.
   `CMTR_ASSERT_IMP(a_ignored_reads_zero, clock, reset, rsp_valid && rsp_access_status,
                    rsp_read_data == 32'd0, "ignored access returned non-zero data")
   // A held request is never dropped while the response side stalls.
   `CMTR_ASSERT_NXT(a_request_held, clock, reset, in_valid_ff && !out_free, in_valid_ff,
                    "request lost while response stalled")
   // Every advanced word shows up as a response.
   `CMTR_ASSERT_NXT(a_fire_gives_rsp, clock, reset, fire, rsp_valid,
                    "advanced word produced no response")

endmodule
